@@ hw/rtl/qwt_pkg.sv @@
package qwt_pkg;

    // scan modes; unused codes behave as between words
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam int KEEP_WS_BIT   = 0;
    localparam int KEEP_HASH_BIT = 1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       word_end;
        logic       line_end;
        logic       comment_cut;
    } t_result;

    localparam t_result RESULT_NONE = '{
        out_byte: CH_NUL, has_byte: 1'b0, word_end: 1'b0,
        line_end: 1'b0, comment_cut: 1'b0
    };

endpackage

@@ hw/rtl/quoted_word_tokenizer.sv @@
// quoted word tokenizer: splits a line of bytes into words
//
// input channel (i_valid / o_ready) takes one byte of a line per handshake,
// with i_line_last marking its final byte; a zero byte also ends the line.
// output channel (o_valid / i_ready) delivers word characters and marks:
// o_has_byte with o_out_byte, o_word_end, o_line_end, o_comment_cut.
// skipped whitespace, opening quotes, escape backslashes and comment bytes
// produce no output word unless they end the line.
// i_cfg_we / i_cfg_data write the 2-bit keep flags (bit0 keep leading
// whitespace, bit1 treat hash as ordinary); write only while idle.
// an emitted output word is registered and appears in the cycle after its byte is accepted.
// throughput: one byte per cycle while the receiver does not stall, set by the single output register.
// when the receiver stalls, the held word stays put and o_ready follows
// i_ready, so a byte can still be taken in the cycle the held word leaves.
// reset (synchronous, active low) clears the keep flags, returns the scan
// mode to between words at line start and empties the output register.
module quoted_word_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_line_last,
    // word output
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_word_end,
    output logic       o_line_end,
    output logic       o_comment_cut,
    // keep flags register
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);
    import qwt_pkg::*;

    logic [1:0] r_keep_flags;
    t_mode      r_mode;
    t_mode      n_mode;
    logic       step_emit;
    t_result    step_result;
    t_result    held_result;
    logic       out_free;
    logic       accept;

    assign o_ready = out_free;
    assign accept  = i_valid && out_free;

    // config register, takes effect from the next byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_flags <= 2'b00;
        end else if (i_cfg_we) begin
            r_keep_flags <= i_cfg_data;
        end
    end

    // per-byte decode of scan mode and result word
    qwt_step u_step (
        .i_mode       (r_mode),
        .i_keep_flags (r_keep_flags),
        .i_in_byte    (i_in_byte),
        .i_line_last  (i_line_last),
        .o_next_mode  (n_mode),
        .o_emit       (step_emit),
        .o_result     (step_result)
    );

    // scan mode advances only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    // output register toward the receiver
    qwt_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && step_emit),
        .i_result (step_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_free   (out_free),
        .o_result (held_result)
    );

    assign o_out_byte    = held_result.out_byte;
    assign o_has_byte    = held_result.has_byte;
    assign o_word_end    = held_result.word_end;
    assign o_line_end    = held_result.line_end;
    assign o_comment_cut = held_result.comment_cut;

endmodule

@@ hw/rtl/qwt_step.sv @@
module qwt_step (
    input  qwt_pkg::t_mode   i_mode,
    input  logic [1:0]       i_keep_flags,
    input  logic [7:0]       i_in_byte,
    input  logic             i_line_last,
    output qwt_pkg::t_mode   o_next_mode,
    output logic             o_emit,
    output qwt_pkg::t_result o_result
);
    import qwt_pkg::*;

    logic is_nul;
    logic is_ws;
    logic is_quote;
    logic is_hash;
    logic is_bsl;
    logic skip_ws;
    logic cut_hash;

    assign is_nul   = (i_in_byte == CH_NUL);
    assign is_ws    = (i_in_byte == CH_SPACE) ||
                      ((i_in_byte >= CH_TAB) && (i_in_byte <= CH_CR));
    assign is_quote = (i_in_byte == CH_QUOTE);
    assign is_hash  = (i_in_byte == CH_HASH);
    assign is_bsl   = (i_in_byte == CH_BSL);
    assign skip_ws  = is_ws && !i_keep_flags[KEEP_WS_BIT];
    assign cut_hash = is_hash && !i_keep_flags[KEEP_HASH_BIT];

    // next mode
    always_comb begin
        o_next_mode = MODE_BETWEEN;
        case (i_mode)
            MODE_PLAIN: begin
                if (!(is_nul || is_ws) && !i_line_last) begin
                    o_next_mode = MODE_PLAIN;
                end
            end
            MODE_QUOTED: begin
                if (!is_nul && !is_quote && !i_line_last) begin
                    o_next_mode = is_bsl ? MODE_ESCAPE : MODE_QUOTED;
                end
            end
            MODE_ESCAPE: begin
                if (!is_nul && !i_line_last) begin
                    o_next_mode = MODE_QUOTED;
                end
            end
            MODE_COMMENT: begin
                if (!is_nul && !i_line_last) begin
                    o_next_mode = MODE_COMMENT;
                end
            end
            default: begin
                if (is_nul || skip_ws || i_line_last) begin
                    o_next_mode = MODE_BETWEEN;
                end else if (cut_hash) begin
                    o_next_mode = MODE_COMMENT;
                end else if (is_quote) begin
                    o_next_mode = MODE_QUOTED;
                end else if (!is_ws) begin
                    o_next_mode = MODE_PLAIN;
                end
            end
        endcase
    end

    // result word
    always_comb begin
        o_emit   = 1'b1;
        o_result = RESULT_NONE;
        case (i_mode)
            MODE_PLAIN: begin
                if (is_nul || is_ws) begin
                    o_result.word_end = 1'b1;
                    o_result.line_end = is_nul | i_line_last;
                end else begin
                    o_result.out_byte = i_in_byte;
                    o_result.has_byte = 1'b1;
                    o_result.word_end = i_line_last;
                    o_result.line_end = i_line_last;
                end
            end
            MODE_QUOTED: begin
                if (is_nul) begin
                    o_result.word_end = 1'b1;
                    o_result.line_end = 1'b1;
                end else if (is_quote) begin
                    o_result.word_end = 1'b1;
                    o_result.line_end = i_line_last;
                end else if (is_bsl) begin
                    // a trailing backslash is kept as a literal
                    o_emit            = i_line_last;
                    o_result.out_byte = CH_BSL;
                    o_result.has_byte = 1'b1;
                    o_result.word_end = 1'b1;
                    o_result.line_end = 1'b1;
                end else begin
                    o_result.out_byte = i_in_byte;
                    o_result.has_byte = 1'b1;
                    o_result.word_end = i_line_last;
                    o_result.line_end = i_line_last;
                end
            end
            MODE_ESCAPE: begin
                if (is_nul) begin
                    o_result.out_byte = CH_BSL;
                    o_result.has_byte = 1'b1;
                    o_result.word_end = 1'b1;
                    o_result.line_end = 1'b1;
                end else begin
                    o_result.out_byte = i_in_byte;
                    o_result.has_byte = 1'b1;
                    o_result.word_end = i_line_last;
                    o_result.line_end = i_line_last;
                end
            end
            MODE_COMMENT: begin
                o_emit               = is_nul | i_line_last;
                o_result.line_end    = 1'b1;
                o_result.comment_cut = 1'b1;
            end
            default: begin
                if (is_nul) begin
                    o_result.line_end = 1'b1;
                end else if (skip_ws) begin
                    o_emit            = i_line_last;
                    o_result.line_end = 1'b1;
                end else if (cut_hash) begin
                    o_emit               = i_line_last;
                    o_result.line_end    = 1'b1;
                    o_result.comment_cut = 1'b1;
                end else if (is_quote) begin
                    o_emit            = i_line_last;
                    o_result.word_end = 1'b1;
                    o_result.line_end = 1'b1;
                end else if (is_ws) begin
                    // kept whitespace closes an empty word
                    o_result.word_end = 1'b1;
                    o_result.line_end = i_line_last;
                end else begin
                    o_result.out_byte = i_in_byte;
                    o_result.has_byte = 1'b1;
                    o_result.word_end = i_line_last;
                    o_result.line_end = i_line_last;
                end
            end
        endcase
    end

endmodule

@@ hw/rtl/qwt_out_stage.sv @@
module qwt_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  qwt_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output qwt_pkg::t_result o_result
);
    import qwt_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
